// ----- src/psched_pkg.sv -----
package psched_pkg;

    // default store size, field widths, queue depth and output saturation limits
    localparam int MAX_JOBS_DEF = 16;
    localparam int TIME_W       = 12;
    localparam int TOTAL_W      = 16;
    localparam int WAIT_MAX     = 4095;
    localparam int TOTAL_MAX    = 65535;
    localparam int QUEUE_DEPTH  = 2;

    // one stored job entry
    typedef struct packed {
        logic [7:0] job_id;
        logic [7:0] burst;
        logic [7:0] prio;
    } job_t;

    // input word
    typedef struct packed {
        logic [7:0] job_id;
        logic [7:0] burst;
        logic [7:0] prio;
        logic       last_job;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [7:0]         out_job_id;
        logic [7:0]         out_burst;
        logic [7:0]         out_prio;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  turnaround;
        logic [TOTAL_W-1:0] total_wait;
        logic [TOTAL_W-1:0] total_turnaround;
        logic               overflowed;
        logic               last_result;
    } out_word_t;

    // classified word passed from front to back
    typedef struct packed {
        in_word_t word;
        logic     keep;
        logic     drop;
    } cmd_t;

endpackage

// ----- src/psched_front.sv -----
module psched_front #(
    parameter int MAX_JOBS = psched_pkg::MAX_JOBS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_stall,
    input  psched_pkg::in_word_t job,
    output logic                cmd_push,
    input  logic                cmd_ready,
    output psched_pkg::cmd_t    cmd
);

    localparam int CW = $clog2(MAX_JOBS + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          drop_reg;
    logic          drop_next;
    logic          keep;

    // classify: store while room is left, otherwise drop and flag
    assign job_stall = !cmd_ready;
    assign cmd_push  = job_valid && cmd_ready;
    assign keep      = count_reg < CW'(MAX_JOBS);

    assign cmd.word = job;
    assign cmd.keep = keep;
    assign cmd.drop = drop_reg || !keep;

    // per-set fill count and drop flag, cleared by the last word
    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        if (cmd_push)
        begin
            if (job.last_job)
            begin
                count_next = '0;
                drop_next  = 1'b0;
            end
            else
            begin
                count_next = count_reg + CW'(keep);
                drop_next  = drop_reg || !keep;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

// ----- src/psched_queue.sv -----
module psched_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  psched_pkg::cmd_t push_word,
    output logic             ready,
    output logic             valid,
    input  logic             pop,
    output psched_pkg::cmd_t head
);

    localparam int DEPTH = psched_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);

    psched_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [FW-1:0]    fill_reg;
    logic             do_push;
    logic             do_pop;

    assign ready   = fill_reg != FW'(DEPTH);
    assign valid   = fill_reg != '0;
    assign do_push = push && ready;
    assign do_pop  = pop && valid;
    assign head    = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - FW'(1);
            end
        end
    end

endmodule

// ----- src/psched_back.sv -----
module psched_back #(
    parameter int MAX_JOBS = psched_pkg::MAX_JOBS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_pop,
    input  psched_pkg::cmd_t      cmd,
    output logic                  sched_valid,
    input  logic                  sched_stall,
    output psched_pkg::out_word_t sched,
    output logic                  busy
);

    localparam int IW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW  = $clog2(MAX_JOBS + 1);
    localparam int WW  = $clog2(MAX_JOBS * 255 + 1);
    localparam int TW  = psched_pkg::TIME_W;
    localparam int OW  = psched_pkg::TOTAL_W;
    localparam int SW  = (WW > TW) ? WW : TW;
    localparam int AW  = OW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_I,
        S_LD_I,
        S_CMP,
        S_EMIT
    } state_t;

    state_t                state_reg;
    psched_pkg::job_t      store_mem [MAX_JOBS];
    psched_pkg::job_t      rd_data_reg;
    psched_pkg::job_t      cur_reg;
    psched_pkg::out_word_t out_reg;
    logic                  out_valid_reg;
    logic [CW-1:0]         wr_cnt_reg;
    logic [CW-1:0]         n_reg;
    logic [IW-1:0]         i_reg;
    logic [IW-1:0]         j_reg;
    logic [WW-1:0]         wait_reg;
    logic [OW-1:0]         tot_w_reg;
    logic [OW-1:0]         tot_t_reg;
    logic                  drop_reg;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    psched_pkg::job_t      wr_data;
    logic [IW-1:0]         rd_addr;
    logic                  swap;
    logic [CW-1:0]         i_inc;
    logic [CW-1:0]         j_inc;
    logic [WW-1:0]         tat;
    logic [TW-1:0]         wait_sat;
    logic [TW-1:0]         tat_sat;
    logic [AW-1:0]         tw_sum;
    logic [AW-1:0]         tt_sum;
    logic [OW-1:0]         tw_sat;
    logic [OW-1:0]         tt_sat;
    logic                  emit_go;

    assign busy        = state_reg != S_IDLE;
    assign cmd_pop     = cmd_valid && (state_reg == S_IDLE);
    assign sched_valid = out_valid_reg;
    assign sched       = out_reg;

    // compare and loop bounds
    assign swap  = cur_reg.prio > rd_data_reg.prio;
    assign i_inc = CW'(i_reg) + CW'(1);
    assign j_inc = CW'(j_reg) + CW'(1);

    // times for the job at position i, saturated for output
    assign tat      = wait_reg + WW'(cur_reg.burst);
    assign wait_sat = (SW'(wait_reg) > SW'(psched_pkg::WAIT_MAX)) ?
                      TW'(psched_pkg::WAIT_MAX) : TW'(wait_reg);
    assign tat_sat  = (SW'(tat) > SW'(psched_pkg::WAIT_MAX)) ?
                      TW'(psched_pkg::WAIT_MAX) : TW'(tat);
    assign tw_sum   = AW'(tot_w_reg) + AW'(wait_reg);
    assign tt_sum   = AW'(tot_t_reg) + AW'(tat);
    assign tw_sat   = (tw_sum > AW'(psched_pkg::TOTAL_MAX)) ?
                      OW'(psched_pkg::TOTAL_MAX) : OW'(tw_sum);
    assign tt_sat   = (tt_sum > AW'(psched_pkg::TOTAL_MAX)) ?
                      OW'(psched_pkg::TOTAL_MAX) : OW'(tt_sum);

    assign emit_go = (state_reg == S_EMIT) && (!out_valid_reg || !sched_stall);

    // store port control: load while idle, swap write during the inner pass
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = j_reg;
        wr_data = cur_reg;
        rd_addr = i_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                wr_en           = cmd_pop && cmd.keep;
                wr_addr         = IW'(wr_cnt_reg);
                wr_data.job_id  = cmd.word.job_id;
                wr_data.burst   = cmd.word.burst;
                wr_data.prio    = cmd.word.prio;
            end
            S_RD_I:
            begin
                rd_addr = i_reg;
            end
            S_LD_I:
            begin
                rd_addr = IW'(i_inc);
            end
            S_CMP:
            begin
                wr_en   = swap;
                rd_addr = IW'(j_inc);
            end
            S_EMIT:
            begin
                rd_addr = i_reg;
            end
            default:
            begin
                rd_addr = i_reg;
            end
        endcase
    end

    // job store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // sequencer: one outer position at a time, minimum carried in cur_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            cur_reg       <= '0;
            wr_cnt_reg    <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            wait_reg      <= '0;
            tot_w_reg     <= '0;
            tot_t_reg     <= '0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!sched_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        if (cmd.word.last_job)
                        begin
                            n_reg      <= wr_cnt_reg + CW'(cmd.keep);
                            wr_cnt_reg <= '0;
                            drop_reg   <= cmd.drop;
                            i_reg      <= '0;
                            wait_reg   <= '0;
                            tot_w_reg  <= '0;
                            tot_t_reg  <= '0;
                            state_reg  <= S_RD_I;
                        end
                        else
                        begin
                            wr_cnt_reg <= wr_cnt_reg + CW'(cmd.keep);
                        end
                    end
                end
                S_RD_I:
                begin
                    state_reg <= S_LD_I;
                end
                S_LD_I:
                begin
                    cur_reg <= rd_data_reg;
                    if (i_inc < n_reg)
                    begin
                        j_reg     <= IW'(i_inc);
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_CMP:
                begin
                    if (swap)
                    begin
                        cur_reg <= rd_data_reg;
                    end
                    if (j_inc < n_reg)
                    begin
                        j_reg <= IW'(j_inc);
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_reg.out_job_id       <= cur_reg.job_id;
                        out_reg.out_burst        <= cur_reg.burst;
                        out_reg.out_prio         <= cur_reg.prio;
                        out_reg.wait_time        <= wait_sat;
                        out_reg.turnaround       <= tat_sat;
                        out_reg.total_wait       <= tw_sat;
                        out_reg.total_turnaround <= tt_sat;
                        out_reg.overflowed       <= drop_reg;
                        out_reg.last_result      <= !(i_inc < n_reg);
                        wait_reg                 <= tat;
                        tot_w_reg                <= tw_sat;
                        tot_t_reg                <= tt_sat;
                        if (i_inc < n_reg)
                        begin
                            i_reg     <= IW'(i_inc);
                            state_reg <= S_RD_I;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/priority_schedule_times.sv -----
// Loading: one job word per cycle while the queue has room, into a two-word queue;
// a non-last word gives no result. Scheduling a set of n jobs starts once its last word
// leaves the queue; each position is read (S_RD_I), loaded (S_LD_I), compared with
// every later job in the job store (S_CMP) and emitted (S_EMIT), one position at a time.
// While a set is scheduled only two words of the next set are taken, then the input stalls.
// Reset clears counters, flags, queue and output valid; the job store is not cleared.
module priority_schedule_times #(
    parameter int MAX_JOBS = psched_pkg::MAX_JOBS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_stall,
    input  psched_pkg::in_word_t  job,
    output logic                  sched_valid,
    input  logic                  sched_stall,
    output psched_pkg::out_word_t sched
);

    logic             q_push;
    logic             q_ready;
    logic             q_valid;
    logic             q_pop;
    psched_pkg::cmd_t q_in;
    psched_pkg::cmd_t q_head;
    logic             back_busy;

    // front: accept and classify
    psched_front #(
        .MAX_JOBS (MAX_JOBS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_stall (job_stall),
        .job       (job),
        .cmd_push  (q_push),
        .cmd_ready (q_ready),
        .cmd       (q_in)
    );

    // decoupling queue
    psched_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in),
        .ready     (q_ready),
        .valid     (q_valid),
        .pop       (q_pop),
        .head      (q_head)
    );

    // back: store, sort and emit
    psched_back #(
        .MAX_JOBS (MAX_JOBS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd_pop     (q_pop),
        .cmd         (q_head),
        .sched_valid (sched_valid),
        .sched_stall (sched_stall),
        .sched       (sched),
        .busy        (back_busy)
    );

`ifndef NO_ASSERTIONS
    // a last word always starts a schedule
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_head.word.last_job |=> back_busy)
        else $error("last word did not start a schedule");

    // a non-last word is only stored or dropped, and starts no schedule
    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && !q_head.word.last_job |=> !back_busy)
        else $error("load word left the back part busy");

    // results only come from a running schedule
    a_result_from_sched: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sched_valid) |-> $past(back_busy))
        else $error("result word without a running schedule");
`endif

endmodule

// ----- verif/psched_checker.sv -----
module psched_checker #(
    parameter int MAX_JOBS = psched_pkg::MAX_JOBS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  logic                  job_stall,
    input  psched_pkg::in_word_t  job,
    input  logic                  sched_valid,
    input  logic                  sched_stall,
    input  psched_pkg::out_word_t sched,
    output int                    mismatches,
    output int                    results_owed,
    output int                    jobs_taken,
    output int                    sets_done,
    output int                    overflow_sets,
    output int                    results_checked
);

    localparam int TW = psched_pkg::TIME_W;
    localparam int OW = psched_pkg::TOTAL_W;

    // jobs of the set being loaded, as the block should hold them
    psched_pkg::job_t        held_jobs [MAX_JOBS];
    int unsigned             held_count   = 0;
    logic                    held_dropped = 1'b0;

    // schedule results still to come, oldest first
    psched_pkg::out_word_t   owed_q [$];

    int err_cnt  = 0;
    int word_cnt = 0;
    int set_cnt  = 0;
    int ovf_cnt  = 0;
    int res_cnt  = 0;

    function automatic int unsigned clip(input int unsigned v, input int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic string show(input psched_pkg::out_word_t r);
        return {$sformatf("id=%0d burst=%0d prio=%0d wait=%0d tat=%0d",
                          r.out_job_id, r.out_burst, r.out_prio, r.wait_time,
                          r.turnaround),
                $sformatf(" tot_wait=%0d tot_tat=%0d ovf=%0b last=%0b",
                          r.total_wait, r.total_turnaround, r.overflowed,
                          r.last_result)};
    endfunction

    // exchange sort on priority, then walk the order building the timing of each job
    task automatic schedule_set();
        psched_pkg::job_t      order [MAX_JOBS];
        psched_pkg::job_t      swap_tmp;
        psched_pkg::out_word_t r;
        int unsigned           start_at;
        int unsigned           finish_at;
        int unsigned           sum_wait;
        int unsigned           sum_tat;
        int                    i;
        int                    j;
        order    = held_jobs;
        start_at = 0;
        sum_wait = 0;
        sum_tat  = 0;
        for (i = 0; i + 1 < int'(held_count); i++)
        begin
            for (j = i + 1; j < int'(held_count); j++)
            begin
                if (order[i].prio > order[j].prio)
                begin
                    swap_tmp = order[i];
                    order[i] = order[j];
                    order[j] = swap_tmp;
                end
            end
        end
        for (i = 0; i < int'(held_count); i++)
        begin
            finish_at            = start_at + order[i].burst;
            sum_wait            += start_at;
            sum_tat             += finish_at;
            r.out_job_id         = order[i].job_id;
            r.out_burst          = order[i].burst;
            r.out_prio           = order[i].prio;
            r.wait_time          = TW'(clip(start_at, psched_pkg::WAIT_MAX));
            r.turnaround         = TW'(clip(finish_at, psched_pkg::WAIT_MAX));
            r.total_wait         = OW'(clip(sum_wait, psched_pkg::TOTAL_MAX));
            r.total_turnaround   = OW'(clip(sum_tat, psched_pkg::TOTAL_MAX));
            r.overflowed         = held_dropped;
            r.last_result        = (i == int'(held_count) - 1);
            owed_q.push_back(r);
            start_at = finish_at;
        end
        set_cnt++;
        if (held_dropped)
            ovf_cnt++;
        held_count   = 0;
        held_dropped = 1'b0;
    endtask

    // store an accepted job word, or drop it once the store is full
    task automatic take_job(input psched_pkg::in_word_t w);
        word_cnt++;
        if (held_count < MAX_JOBS)
        begin
            held_jobs[held_count] = '{job_id: w.job_id, burst: w.burst, prio: w.prio};
            held_count++;
        end
        else
        begin
            held_dropped = 1'b1;
        end
        if (w.last_job)
            schedule_set();
    endtask

    // compare a result word with the oldest one owed
    task automatic check_result(input psched_pkg::out_word_t got);
        psched_pkg::out_word_t want;
        if (owed_q.size() == 0)
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("unexpected result word: %s", show(got));
        end
        else
        begin
            want = owed_q.pop_front();
            res_cnt++;
            if (got.out_job_id !== want.out_job_id || got.out_burst !== want.out_burst ||
                got.out_prio !== want.out_prio || got.wait_time !== want.wait_time ||
                got.turnaround !== want.turnaround || got.total_wait !== want.total_wait ||
                got.total_turnaround !== want.total_turnaround ||
                got.overflowed !== want.overflowed || got.last_result !== want.last_result)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                begin
                    $display("result %0d differs", res_cnt);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (job_valid && !job_stall)
                take_job(job);
            if (sched_valid && !sched_stall)
                check_result(sched);
        end
        mismatches      <= err_cnt;
        results_owed    <= owed_q.size();
        jobs_taken      <= word_cnt;
        sets_done       <= set_cnt;
        overflow_sets   <= ovf_cnt;
        results_checked <= res_cnt;
    end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;

    localparam int     RANDOM_WORDS = 100;
    localparam int     LONG_HOLD    = 400;
    localparam int     DRAIN_CYCLES = 250;
    localparam longint TIME_LIMIT   = 20_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  job_valid;
    logic                  job_stall;
    psched_pkg::in_word_t  job;
    logic                  sched_valid;
    logic                  sched_stall;
    psched_pkg::out_word_t sched;

    // set by the stimulus, taken up once by the receiver
    bit        long_hold_req = 1'b0;

    int mismatches;
    int results_owed;
    int jobs_taken;
    int sets_done;
    int overflow_sets;
    int results_checked;

    always #6 clk = ~clk;

    priority_schedule_times dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_stall   (job_stall),
        .job         (job),
        .sched_valid (sched_valid),
        .sched_stall (sched_stall),
        .sched       (sched)
    );

    psched_checker sched_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (job_valid),
        .job_stall       (job_stall),
        .job             (job),
        .sched_valid     (sched_valid),
        .sched_stall     (sched_stall),
        .sched           (sched),
        .mismatches      (mismatches),
        .results_owed    (results_owed),
        .jobs_taken      (jobs_taken),
        .sets_done       (sets_done),
        .overflow_sets   (overflow_sets),
        .results_checked (results_checked)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic psched_pkg::in_word_t make_word(input logic [7:0] id,
                                                       input logic [7:0] burst,
                                                       input logic [7:0] prio,
                                                       input logic last);
        psched_pkg::in_word_t w;
        w.job_id   = id;
        w.burst    = burst;
        w.prio     = prio;
        w.last_job = last;
        return w;
    endfunction

    // offer one word until taken, then optionally go idle with junk on the bus
    task automatic send_word(input psched_pkg::in_word_t w, input int gap);
        psched_pkg::in_word_t junk;
        job       <= w;
        job_valid <= 1'b1;
        @(posedge clk);
        while (job_stall)
            @(posedge clk);
        if (gap > 0)
        begin
            junk       = make_word(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
            job_valid <= 1'b0;
            job       <= junk;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait for every owed result
    task automatic wait_for_drain();
        job_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        int sent;
        int set_no;
        int set_len;
        int span;
        int roll;
        int k;
        bit quiet;
        rst_n     = 1'b0;
        job_valid = 1'b0;
        job       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single jobs at both extremes
        send_word(make_word(8'd0, 8'd0, 8'd0, 1'b1), pick_gap());
        send_word(make_word(8'hff, 8'hff, 8'hff, 1'b1), pick_gap());
        // equal priorities, order left by the sort
        send_word(make_word(8'd1, 8'd10, 8'd5, 1'b0), pick_gap());
        send_word(make_word(8'd2, 8'd20, 8'd5, 1'b0), pick_gap());
        send_word(make_word(8'd3, 8'd30, 8'd5, 1'b1), pick_gap());
        // full store in reverse priority order, then a dropped last word
        for (k = 0; k < psched_pkg::MAX_JOBS_DEF; k++)
            send_word(make_word(8'(16 + k), 8'hff, 8'(255 - 17 * k), 1'b0), 0);
        send_word(make_word(8'd99, 8'd42, 8'd7, 1'b1), pick_gap());
        wait_for_drain();

        // random sets; the first one meets a long receiver hold-off
        long_hold_req = 1'b1;
        sent   = 0;
        set_no = 0;
        while (sent < RANDOM_WORDS)
        begin
            roll    = $urandom_range(0, 99);
            set_len = (roll < 70) ? $urandom_range(1, 5) :
                      (roll < 92) ? $urandom_range(6, 15) : $urandom_range(16, 20);
            span    = $urandom_range(0, 1) ? 255 : 3;
            quiet   = ($urandom_range(0, 3) == 0);
            if (set_no == 0)
            begin
                set_len = psched_pkg::MAX_JOBS_DEF;
                quiet   = 1'b1;
            end
            for (k = 0; k < set_len; k++)
                send_word(make_word(8'($urandom), 8'($urandom), 8'($urandom_range(0, span)),
                                    k == set_len - 1), quiet ? 0 : pick_gap());
            sent += set_len;
            set_no++;
            if (set_no == 8)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d job words in %0d sets, %0d of them over capacity",
                 jobs_taken, sets_done, overflow_sets);
        $display("%0d schedule results compared, with one receiver hold-off of %0d cycles",
                 results_checked, LONG_HOLD);
        if (results_owed != 0)
            $display("%0d owed results never arrived", results_owed);
        if (mismatches == 0 && results_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver side stalls
    initial
    begin
        int hold;
        bit hold_done;
        hold_done   = 1'b0;
        sched_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold_req && !hold_done)
            begin
                hold_done    = 1'b1;
                sched_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if ($urandom_range(0, 24) == 0)
            begin
                sched_stall <= 1'b0;
                repeat (40) @(posedge clk);
            end
            else
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    sched_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                end
                sched_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // guard against a hung run
    initial
    begin
        #(TIME_LIMIT);
        $display("run stopped at the time limit");
        $display("Mismatches found");
        $finish;
    end

endmodule
